### hw/rtl/i2c_eeprom_page_master_assert.svh
// ----------------------------------------------------------------------------
// I2C EEPROM page master - assertion macros
// Shorthand for clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_PAGE_MASTER_ASSERT_SVH
`define I2C_EEPROM_PAGE_MASTER_ASSERT_SVH

// same-cycle implication
`define I2CEP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/i2cep_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM page master - package
// Sequencer state codes, bus constants and the structs passed between units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cep_pkg;

  // command kinds
  localparam logic [1:0] OP_NONE      = 2'd0;
  localparam logic [1:0] OP_READ      = 2'd1;
  localparam logic [1:0] OP_WRITE     = 2'd2;
  localparam logic [1:0] OP_BUS_RESET = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_HALF_PHASE = 2'd0;
  localparam logic [1:0] CFG_IDX_WRITE_WAIT = 2'd1;
  localparam logic [1:0] CFG_IDX_PAGE_SIZE  = 2'd2;

  localparam logic [19:0] WRITE_WAIT_RESET = 20'd1250;

  // device byte
  localparam logic [7:0]  DEV_BASE    = 8'hA0;
  localparam logic [13:0] BANK_LIMIT  = 14'h1FF;
  localparam logic [7:0]  BANK_BIT    = 8'h08;
  localparam logic [7:0]  SLAVE_MASK  = 8'h06;
  localparam logic [7:0]  BYTE_MSB    = 8'h80;

  // byte positions in the header
  localparam logic [7:0] BYTE_ADDR_HI = 8'd1;
  localparam logic [7:0] BYTE_ADDR_LO = 8'd2;
  localparam logic [7:0] HDR_BYTES    = 8'd3;

  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
  localparam logic [3:0] RESET_PULSES   = 4'd9;
  localparam logic [7:0] SHORT_PAGE_LEN = 8'd32;

  typedef enum logic [23:0] {
    ST_IDLE       = 24'h000001,
    ST_START_A    = 24'h000002,
    ST_START_B    = 24'h000004,
    ST_START_C    = 24'h000008,
    ST_START_D    = 24'h000010,
    ST_TX_DATA    = 24'h000020,
    ST_TX_HIGH    = 24'h000040,
    ST_TX_ACKREL  = 24'h000080,
    ST_TX_ACKHIGH = 24'h000100,
    ST_TX_ACKEND  = 24'h000200,
    ST_WDATA      = 24'h000400,
    ST_WAIT       = 24'h000800,
    ST_RX_REL     = 24'h001000,
    ST_RX_HIGH    = 24'h002000,
    ST_RX_LOW     = 24'h004000,
    ST_RX_ACK     = 24'h008000,
    ST_RX_ACKHIGH = 24'h010000,
    ST_STOP_A     = 24'h020000,
    ST_STOP_B     = 24'h040000,
    ST_STOP_C     = 24'h080000,
    ST_RST_A      = 24'h100000,
    ST_RST_B      = 24'h200000,
    ST_RST_C      = 24'h400000,
    ST_RST_D      = 24'h800000
  } seq_state_e;

  typedef struct packed {
    logic [15:0] half_phase_ticks;
    logic [19:0] write_wait_ticks;
    logic        page_size_sel;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [13:0] page;
    logic [1:0]  slave_addr;
    logic        wdata_valid;
    logic [7:0]  wdata;
    logic        scl_in;
    logic        sda_in;
  } tick_in_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       wdata_req;
    logic       rdata_valid;
    logic [7:0] rdata;
    logic       rdata_last;
    logic       done_res;
  } tick_res_t;

endpackage

`default_nettype wire

### hw/rtl/i2cep_cfg_regs.sv
// ----------------------------------------------------------------------------
// I2C EEPROM page master - configuration registers
// Timing and page size registers behind a valid/ready write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cep_cfg_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [1:0]    cfg_index_i,
  input  wire logic [19:0]   cfg_data_i,
  output i2cep_pkg::cfg_t    cfg_o
);
  import i2cep_pkg::*;

  logic [15:0] half_q;
  logic [19:0] wait_q;
  logic        sel_q;
  logic        wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= '0;
      wait_q <= WRITE_WAIT_RESET;
      sel_q  <= 1'b1;
    end else if (wr_en) begin
      case (cfg_index_i)
        CFG_IDX_HALF_PHASE: half_q <= cfg_data_i[15:0];
        CFG_IDX_WRITE_WAIT: wait_q <= cfg_data_i;
        CFG_IDX_PAGE_SIZE:  sel_q  <= cfg_data_i[0];
        default: ;  // no register there
      endcase
    end
  end

  assign cfg_o = '{half_phase_ticks: half_q, write_wait_ticks: wait_q, page_size_sel: sel_q};

endmodule

`default_nettype wire

### hw/rtl/i2cep_seq.sv
// ----------------------------------------------------------------------------
// I2C EEPROM page master - bit sequencer
// Holds the bus sequencer state and advances it by one tick per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cep_seq #(
  parameter int unsigned MAX_PAGE_BYTES = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  i2cep_pkg::tick_in_t      tick_i,
  input  i2cep_pkg::cfg_t          cfg_i,
  output i2cep_pkg::tick_res_t     res_o
);
  import i2cep_pkg::*;

  localparam int unsigned LongLen = (MAX_PAGE_BYTES < 128) ? MAX_PAGE_BYTES : 128;
  localparam logic [7:0]  LONG_PAGE_LEN = 8'(LongLen);

  seq_state_e  state_q, state_d;
  logic [19:0] tick_q, tick_d;
  logic [1:0]  line_q, line_d;    // bit 0 SCL low, bit 1 SDA low
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  shift_q, shift_d;
  logic [13:0] page_q, page_d;
  logic [1:0]  slave_q, slave_d;
  logic [1:0]  kind_q, kind_d;

  seq_state_e go_st;
  logic       go_enter, go_scl, go_sda;
  logic       tx_load;
  logic [7:0] tx_byte;
  logic       rx_valid, rx_last, done;
  logic [7:0] rx_byte;

  logic [7:0] page_len;
  logic [7:0] byte_inc;
  logic [3:0] bit_inc;
  logic [7:0] shift_tx;
  logic [7:0] dev_byte;
  logic [7:0] addr_hi, addr_lo;
  logic       sda_now;

  assign page_len = cfg_i.page_size_sel ? LONG_PAGE_LEN : SHORT_PAGE_LEN;
  assign byte_inc = byte_q + 8'd1;
  assign bit_inc  = bit_q + 4'd1;
  assign shift_tx = {shift_q[6:0], 1'b0};
  assign sda_now  = line_q[1];
  assign addr_hi  = cfg_i.page_size_sel ? page_q[8:1] : page_q[10:3];
  assign addr_lo  = cfg_i.page_size_sel ? {page_q[0], 7'd0} : {page_q[2:0], 5'd0};

  always_comb begin
    dev_byte = DEV_BASE | ((page_q > BANK_LIMIT) ? BANK_BIT : 8'd0)
             | ({5'd0, slave_q, 1'b0} & SLAVE_MASK);
    if (kind_q == OP_READ && byte_q == HDR_BYTES) begin
      dev_byte[0] = 1'b1;
    end
  end

  always_comb begin
    state_d  = state_q;
    tick_d   = tick_q;
    line_d   = line_q;
    bit_d    = bit_q;
    byte_d   = byte_q;
    shift_d  = shift_q;
    page_d   = page_q;
    slave_d  = slave_q;
    kind_d   = kind_q;
    go_enter = 1'b0;
    go_st    = state_q;
    go_scl   = 1'b0;
    go_sda   = 1'b0;
    tx_load  = 1'b0;
    tx_byte  = '0;
    rx_valid = 1'b0;
    rx_byte  = '0;
    rx_last  = 1'b0;
    done     = 1'b0;

    if (step_i) begin
      case (state_q)
        ST_IDLE: begin
          if (tick_i.operation != OP_NONE) begin
            kind_d   = tick_i.operation;
            page_d   = tick_i.page;
            slave_d  = tick_i.slave_addr;
            bit_d    = '0;
            byte_d   = '0;
            shift_d  = '0;
            go_enter = 1'b1;
            if (tick_i.operation == OP_BUS_RESET) begin
              go_st  = ST_RST_A;
              go_scl = line_q[0];
              go_sda = 1'b1;
            end else begin
              go_st  = ST_START_A;
              go_sda = sda_now;
            end
          end
        end
        ST_WDATA: begin
          if (tick_i.wdata_valid) begin
            tx_load = 1'b1;
            tx_byte = tick_i.wdata;
          end
        end
        ST_WAIT: begin
          if (tick_q < cfg_i.write_wait_ticks) begin
            tick_d = tick_q + 20'd1;
          end else if (kind_q == OP_READ) begin
            go_enter = 1'b1;
            go_st    = ST_START_A;
            go_sda   = sda_now;
          end else begin
            go_enter = 1'b1;
            go_st    = ST_IDLE;
            done     = 1'b1;
          end
        end
        default: begin
          if (tick_q < {4'd0, cfg_i.half_phase_ticks}) begin
            tick_d = tick_q + 20'd1;
          end else if (!line_q[0] && !tick_i.scl_in) begin
            // slave holds SCL low
          end else begin
            go_enter = 1'b1;
            case (state_q)
              ST_START_A: go_st = ST_START_B;
              ST_START_B: begin
                go_st  = ST_START_C;
                go_sda = 1'b1;
              end
              ST_START_C: begin
                go_st  = ST_START_D;
                go_scl = 1'b1;
                go_sda = 1'b1;
              end
              ST_START_D: begin
                tx_load = 1'b1;
                tx_byte = dev_byte;
              end
              ST_TX_DATA: begin
                go_st  = ST_TX_HIGH;
                go_sda = sda_now;
              end
              ST_TX_HIGH: begin
                shift_d = shift_tx;
                bit_d   = bit_inc;
                go_scl  = 1'b1;
                if (bit_inc >= BITS_PER_BYTE) begin
                  go_st = ST_TX_ACKREL;
                end else begin
                  go_st  = ST_TX_DATA;
                  go_sda = ~shift_tx[7];
                end
              end
              ST_TX_ACKREL: go_st = ST_TX_ACKHIGH;
              ST_TX_ACKHIGH: begin
                go_st  = ST_TX_ACKEND;
                go_scl = 1'b1;
                go_sda = 1'b1;
              end
              ST_TX_ACKEND: begin
                byte_d = byte_inc;
                go_scl = 1'b1;
                if (byte_inc == BYTE_ADDR_HI) begin
                  tx_load = 1'b1;
                  tx_byte = addr_hi;
                end else if (byte_inc == BYTE_ADDR_LO) begin
                  tx_load = 1'b1;
                  tx_byte = addr_lo;
                end else if (kind_q == OP_READ) begin
                  if (byte_inc == HDR_BYTES) begin
                    go_st  = ST_WAIT;
                    go_sda = 1'b1;
                  end else begin
                    // repeated START done: start reading the page
                    byte_d = '0;
                    bit_d  = '0;
                    go_st  = ST_RX_REL;
                  end
                end else if ({1'b0, byte_inc} < {1'b0, HDR_BYTES} + {1'b0, page_len}) begin
                  go_st  = ST_WDATA;
                  go_sda = 1'b1;
                end else begin
                  go_st  = ST_STOP_A;
                  go_sda = 1'b1;
                end
              end
              ST_RX_REL: go_st = ST_RX_HIGH;
              ST_RX_HIGH: begin
                shift_d = {shift_q[6:0], tick_i.sda_in};
                bit_d   = bit_inc;
                go_st   = ST_RX_LOW;
                go_scl  = 1'b1;
              end
              ST_RX_LOW: begin
                if (bit_q >= BITS_PER_BYTE) begin
                  rx_last  = ({1'b0, byte_q} + 9'd1) >= {1'b0, page_len};
                  rx_valid = 1'b1;
                  rx_byte  = shift_q;
                  go_st    = ST_RX_ACK;
                  go_scl   = 1'b1;
                  go_sda   = ~rx_last;   // ACK, or NACK on the last byte
                end else begin
                  go_st = ST_RX_HIGH;
                end
              end
              ST_RX_ACK: begin
                go_st  = ST_RX_ACKHIGH;
                go_sda = sda_now;
              end
              ST_RX_ACKHIGH: begin
                byte_d = byte_inc;
                go_scl = 1'b1;
                if (byte_inc >= page_len) begin
                  go_st  = ST_STOP_A;
                  go_sda = 1'b1;
                end else begin
                  bit_d = '0;
                  go_st = ST_RX_REL;
                end
              end
              ST_STOP_A: begin
                go_st  = ST_STOP_B;
                go_sda = 1'b1;
              end
              ST_STOP_B: go_st = ST_STOP_C;
              ST_STOP_C: begin
                if (kind_q == OP_WRITE) begin
                  go_st = ST_WAIT;
                end else begin
                  go_st = ST_IDLE;
                  done  = 1'b1;
                end
              end
              ST_RST_A: begin
                go_st  = ST_RST_B;
                go_scl = 1'b1;
                go_sda = 1'b1;
              end
              ST_RST_B: begin
                go_st  = ST_RST_C;
                go_scl = 1'b1;
              end
              ST_RST_C: go_st = ST_RST_D;
              ST_RST_D: begin
                bit_d = bit_inc;
                if (bit_inc >= RESET_PULSES) begin
                  go_st = ST_IDLE;
                  done  = 1'b1;
                end else begin
                  go_st  = ST_RST_A;
                  go_sda = 1'b1;
                end
              end
              default: begin
                go_st = ST_IDLE;
                done  = 1'b1;
              end
            endcase
          end
        end
      endcase
    end

    if (tx_load) begin
      shift_d  = tx_byte;
      bit_d    = '0;
      go_enter = 1'b1;
      go_st    = ST_TX_DATA;
      go_scl   = 1'b1;
      go_sda   = ~(|(tx_byte & BYTE_MSB));
    end

    if (go_enter) begin
      state_d = go_st;
      tick_d  = '0;
      line_d  = {go_sda, go_scl};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      line_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      page_q  <= '0;
      slave_q <= '0;
      kind_q  <= '0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      line_q  <= line_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      page_q  <= page_d;
      slave_q <= slave_d;
      kind_q  <= kind_d;
    end
  end

  assign res_o = '{
    scl_low:     line_d[0],
    sda_low:     line_d[1],
    busy_res:    (state_d != ST_IDLE),
    wdata_req:   (state_d == ST_WDATA),
    rdata_valid: rx_valid,
    rdata:       rx_byte,
    rdata_last:  rx_last,
    done_res:    done
  };

endmodule

`default_nettype wire

### hw/rtl/i2c_eeprom_page_master.sv
// ----------------------------------------------------------------------------
// I2C EEPROM page master - top level
// Each accepted transaction is one tick of an open-drain I2C master that reads
// or writes one page of a serial EEPROM, or clocks nine pulses to free a hung
// bus; every tick yields exactly one result transaction with the line drives,
// status and any read byte. One tick is taken per clock unless an output stall
// holds the input side: the input register feeds the combinational sequencer
// step, whose outcome lands in the output register, so a result passes the input
// register and then the output register, and the sequencer state loop closes
// through its own state register. An output stall holds the input side only once
// both registers are full. The bus timing is counted in ticks, not clocks: each
// bus step lasts half_phase_ticks+1 ticks (longer while the slave stretches SCL),
// the wait after a write STOP or a read address lasts write_wait_ticks+1 ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_page_master #(
  parameter int unsigned MAX_PAGE_BYTES = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tick channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [13:0] page_i,
  input  wire logic [1:0]  slave_addr_i,
  input  wire logic        wdata_valid_i,
  input  wire logic [7:0]  wdata_i,
  input  wire logic        scl_in_i,
  input  wire logic        sda_in_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             scl_low_o,
  output logic             sda_low_o,
  output logic             busy_res_o,
  output logic             wdata_req_o,
  output logic             rdata_valid_o,
  output logic [7:0]       rdata_o,
  output logic             rdata_last_o,
  output logic             done_res_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i
);
  import i2cep_pkg::*;

  cfg_t      cfg;
  tick_in_t  in_q;
  logic      in_valid_q;
  tick_res_t step_res;
  tick_res_t res_q;
  logic      out_valid_q;
  logic      in_accept;
  logic      step;

  assign step       = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~step;
  assign in_accept  = in_valid_i & ~in_stall_o;

  i2cep_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2cep_seq #(
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .tick_i (in_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= '{operation: operation_i, page: page_i, slave_addr: slave_addr_i,
                wdata_valid: wdata_valid_i, wdata: wdata_i,
                scl_in: scl_in_i, sda_in: sda_in_i};
    end
    if (step) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_low_o     = res_q.scl_low;
  assign sda_low_o     = res_q.sda_low;
  assign busy_res_o    = res_q.busy_res;
  assign wdata_req_o   = res_q.wdata_req;
  assign rdata_valid_o = res_q.rdata_valid;
  assign rdata_o       = res_q.rdata;
  assign rdata_last_o  = res_q.rdata_last;
  assign done_res_o    = res_q.done_res;

endmodule

`default_nettype wire

### hw/rtl/i2cep_checker.sv
// ----------------------------------------------------------------------------
// I2C EEPROM page master - port checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_eeprom_page_master_assert.svh"

module i2cep_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       scl_low_o,
  input wire logic       sda_low_o,
  input wire logic       busy_res_o,
  input wire logic       wdata_req_o,
  input wire logic       rdata_valid_o,
  input wire logic [7:0] rdata_o,
  input wire logic       rdata_last_o,
  input wire logic       done_res_o
);

  // a stalled result transaction holds
  `I2CEP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(rdata_o) && $stable(busy_res_o), "stalled result changed")

  // a finished command leaves the bus released and the block idle
  `I2CEP_ASSERT_NOW(a_done_idle, out_valid_o && done_res_o, !busy_res_o && !scl_low_o && !sda_low_o, "done without idle bus")

  // waiting for write data keeps both lines low mid-command
  `I2CEP_ASSERT_NOW(a_wreq_lines, out_valid_o && wdata_req_o, busy_res_o && scl_low_o && sda_low_o, "write request with bus not held")

  // read byte fields are zero without a read byte, and a read byte is never the end
  `I2CEP_ASSERT_NOW(a_rdata_quiet, out_valid_o && !rdata_valid_o, rdata_o == 8'd0 && !rdata_last_o, "read fields set without read byte")
  `I2CEP_ASSERT_NOW(a_rdata_busy, out_valid_o && rdata_valid_o, busy_res_o && !done_res_o, "read byte outside a command")

endmodule

bind i2c_eeprom_page_master i2cep_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .scl_low_o     (scl_low_o),
  .sda_low_o     (sda_low_o),
  .busy_res_o    (busy_res_o),
  .wdata_req_o   (wdata_req_o),
  .rdata_valid_o (rdata_valid_o),
  .rdata_o       (rdata_o),
  .rdata_last_o  (rdata_last_o),
  .done_res_o    (done_res_o)
);

`default_nettype wire

### bench/i2c_eeprom_page_master_tb.sv
// ----------------------------------------------------------------------------
// I2C EEPROM page master - testbench
// Drives bus ticks into the sequencer and checks the line drives, status and
// read bytes of every tick against an in-bench model of the page sequencer.
// Directed commands cover the header extremes, bank select, clock stretching
// and live register changes; random phases then run whole page reads, page
// writes and bus recoveries under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import i2cep_pkg::*;

class tick_scoreboard #(int PAGE_CAP = 128);
  logic [15:0] half_phase = '0;
  logic [19:0] wait_ticks = WRITE_WAIT_RESET;
  logic        page_sel   = 1'b1;

  seq_state_e  st        = ST_IDLE;
  logic [3:0]  bit_cnt   = '0;
  logic [7:0]  byte_cnt  = '0;
  logic [7:0]  shreg     = '0;
  logic [19:0] tick_cnt  = '0;
  logic [13:0] cmd_page  = '0;
  logic [1:0]  cmd_slave = '0;
  logic [1:0]  cmd_kind  = OP_NONE;
  logic        scl_drv   = 1'b0;
  logic        sda_drv   = 1'b0;
  tick_res_t   outcome;

  tick_res_t   pending_tick_res[$];
  int unsigned errors = 0;

  function void set_reg(logic [1:0] idx, logic [19:0] val);
    case (idx)
      CFG_IDX_HALF_PHASE: half_phase = val[15:0];
      CFG_IDX_WRITE_WAIT: wait_ticks = val;
      CFG_IDX_PAGE_SIZE:  page_sel   = val[0];
      default: ;
    endcase
  endfunction

  function bit idle();
    return st == ST_IDLE;
  endfunction

  function int page_len();
    int n;
    // long pages are four times the short ones
    n = page_sel ? int'(SHORT_PAGE_LEN) << 2 : int'(SHORT_PAGE_LEN);
    return n > PAGE_CAP ? PAGE_CAP : n;
  endfunction

  function void enter(seq_state_e nxt, logic scl_l, logic sda_l);
    st       = nxt;
    tick_cnt = '0;
    scl_drv  = scl_l;
    sda_drv  = sda_l;
  endfunction

  function void send_byte(logic [7:0] v);
    shreg   = v;
    bit_cnt = '0;
    enter(ST_TX_DATA, 1'b1, !v[7]);
  endfunction

  function void end_command();
    enter(ST_IDLE, 1'b0, 1'b0);
    outcome.done_res = 1'b1;
  endfunction

  function void next_after_ack();
    int s;
    int p;
    s = page_sel ? 7 : 5;
    p = cmd_page;
    byte_cnt = byte_cnt + 1'b1;
    if (byte_cnt == BYTE_ADDR_HI) begin
      send_byte(8'(p >> (8 - s)));
    end else if (byte_cnt == BYTE_ADDR_LO) begin
      send_byte(8'(p << s));
    end else if (cmd_kind == OP_READ) begin
      if (byte_cnt == HDR_BYTES) begin
        enter(ST_WAIT, 1'b1, 1'b1);
      end else begin
        byte_cnt = '0;
        bit_cnt  = '0;
        enter(ST_RX_REL, 1'b1, 1'b0);
      end
    end else if (int'(byte_cnt) < int'(HDR_BYTES) + page_len()) begin
      enter(ST_WDATA, 1'b1, 1'b1);
    end else begin
      enter(ST_STOP_A, 1'b1, 1'b1);
    end
  endfunction

  function void advance(logic sda);
    logic [7:0] dev;
    logic       last;
    case (st)
      ST_START_A: enter(ST_START_B, 1'b0, 1'b0);
      ST_START_B: enter(ST_START_C, 1'b0, 1'b1);
      ST_START_C: enter(ST_START_D, 1'b1, 1'b1);
      ST_START_D: begin
        dev = DEV_BASE | (cmd_page > BANK_LIMIT ? BANK_BIT : 8'h00)
            | ({5'b0, cmd_slave, 1'b0} & SLAVE_MASK);
        // repeated start of a read carries R/W set
        if (cmd_kind == OP_READ && byte_cnt == HDR_BYTES) dev[0] = 1'b1;
        send_byte(dev);
      end
      ST_TX_DATA: enter(ST_TX_HIGH, 1'b0, sda_drv);
      ST_TX_HIGH: begin
        shreg = shreg << 1;
        bit_cnt++;
        if (bit_cnt >= BITS_PER_BYTE) enter(ST_TX_ACKREL, 1'b1, 1'b0);
        else enter(ST_TX_DATA, 1'b1, !shreg[7]);
      end
      ST_TX_ACKREL:  enter(ST_TX_ACKHIGH, 1'b0, 1'b0);
      ST_TX_ACKHIGH: enter(ST_TX_ACKEND, 1'b1, 1'b1);
      ST_TX_ACKEND:  next_after_ack();
      ST_RX_REL:     enter(ST_RX_HIGH, 1'b0, 1'b0);
      ST_RX_HIGH: begin
        shreg = {shreg[6:0], sda};
        bit_cnt++;
        enter(ST_RX_LOW, 1'b1, 1'b0);
      end
      ST_RX_LOW: begin
        if (bit_cnt >= BITS_PER_BYTE) begin
          last = int'(byte_cnt) + 1 >= page_len();
          outcome.rdata_valid = 1'b1;
          outcome.rdata       = shreg;
          outcome.rdata_last  = last;
          enter(ST_RX_ACK, 1'b1, !last);
        end else begin
          enter(ST_RX_HIGH, 1'b0, 1'b0);
        end
      end
      ST_RX_ACK: enter(ST_RX_ACKHIGH, 1'b0, sda_drv);
      ST_RX_ACKHIGH: begin
        byte_cnt = byte_cnt + 1'b1;
        if (int'(byte_cnt) >= page_len()) begin
          enter(ST_STOP_A, 1'b1, 1'b1);
        end else begin
          bit_cnt = '0;
          enter(ST_RX_REL, 1'b1, 1'b0);
        end
      end
      ST_STOP_A: enter(ST_STOP_B, 1'b0, 1'b1);
      ST_STOP_B: enter(ST_STOP_C, 1'b0, 1'b0);
      ST_STOP_C: begin
        if (cmd_kind == OP_WRITE) enter(ST_WAIT, 1'b0, 1'b0);
        else end_command();
      end
      ST_RST_A: enter(ST_RST_B, 1'b1, 1'b1);
      ST_RST_B: enter(ST_RST_C, 1'b1, 1'b0);
      ST_RST_C: enter(ST_RST_D, 1'b0, 1'b0);
      ST_RST_D: begin
        bit_cnt++;
        if (bit_cnt >= RESET_PULSES) end_command();
        else enter(ST_RST_A, 1'b0, 1'b1);
      end
      default: end_command();
    endcase
  endfunction

  // one accepted tick transaction: step the sequencer and queue its result
  function void take_tick(tick_in_t t);
    outcome = '0;
    if (st == ST_IDLE) begin
      if (t.operation != OP_NONE) begin
        cmd_kind  = t.operation;
        cmd_page  = t.page;
        cmd_slave = t.slave_addr;
        bit_cnt   = '0;
        byte_cnt  = '0;
        shreg     = '0;
        if (t.operation == OP_BUS_RESET) enter(ST_RST_A, scl_drv, 1'b1);
        else enter(ST_START_A, 1'b0, sda_drv);
      end
    end else if (st == ST_WDATA) begin
      if (t.wdata_valid) send_byte(t.wdata);
    end else if (st == ST_WAIT) begin
      if (tick_cnt < wait_ticks) tick_cnt++;
      else if (cmd_kind == OP_READ) enter(ST_START_A, 1'b0, sda_drv);
      else end_command();
    end else if (tick_cnt < 20'(half_phase)) begin
      tick_cnt++;
    end else if (!scl_drv && !t.scl_in) begin
      // slave holds SCL low: step does not end
    end else begin
      advance(t.sda_in);
    end
    outcome.scl_low   = scl_drv;
    outcome.sda_low   = sda_drv;
    outcome.busy_res  = st != ST_IDLE;
    outcome.wdata_req = st == ST_WDATA;
    pending_tick_res.push_back(outcome);
  endfunction

  function void compare(string field, int unsigned want, int unsigned seen);
    if (want == seen) return;
    errors++;
    if (errors <= 40)
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, seen);
  endfunction

  function void check_result(tick_res_t got);
    tick_res_t want;
    if (pending_tick_res.size() == 0) begin
      errors++;
      if (errors <= 40) $display("%0t: result transaction with no tick pending", $time);
      return;
    end
    want = pending_tick_res.pop_front();
    compare("scl_low", want.scl_low, got.scl_low);
    compare("sda_low", want.sda_low, got.sda_low);
    compare("busy_res", want.busy_res, got.busy_res);
    compare("wdata_req", want.wdata_req, got.wdata_req);
    compare("rdata_valid", want.rdata_valid, got.rdata_valid);
    compare("rdata", want.rdata, got.rdata);
    compare("rdata_last", want.rdata_last, got.rdata_last);
    compare("done_res", want.done_res, got.done_res);
  endfunction
endclass

module i2c_eeprom_page_master_tb;

  localparam int unsigned PAGE_CAP = 128;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [1:0]  operation   = OP_NONE;
  logic [13:0] page        = '0;
  logic [1:0]  slave_addr  = '0;
  logic        wdata_valid = 1'b0;
  logic [7:0]  wdata       = '0;
  logic        scl_in      = 1'b1;
  logic        sda_in      = 1'b1;
  logic        out_stall   = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic [1:0]  cfg_index   = CFG_IDX_HALF_PHASE;
  logic [19:0] cfg_data    = '0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        scl_low_o;
  logic        sda_low_o;
  logic        busy_res_o;
  logic        wdata_req_o;
  logic        rdata_valid_o;
  logic [7:0]  rdata_o;
  logic        rdata_last_o;
  logic        done_res_o;
  logic        cfg_ready_o;

  tick_scoreboard #(PAGE_CAP) sb = new;

  bit          calm        = 1'b0;
  int unsigned stretch_left = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  int unsigned res_seen    = 0;

  i2c_eeprom_page_master #(
    .MAX_PAGE_BYTES(PAGE_CAP)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .page_i        (page),
    .slave_addr_i  (slave_addr),
    .wdata_valid_i (wdata_valid),
    .wdata_i       (wdata),
    .scl_in_i      (scl_in),
    .sda_in_i      (sda_in),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .scl_low_o     (scl_low_o),
    .sda_low_o     (sda_low_o),
    .busy_res_o    (busy_res_o),
    .wdata_req_o   (wdata_req_o),
    .rdata_valid_o (rdata_valid_o),
    .rdata_o       (rdata_o),
    .rdata_last_o  (rdata_last_o),
    .done_res_o    (done_res_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned gap_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic tick_in_t make_tick(bit allow_cmd);
    tick_in_t    t;
    int unsigned r;
    r = $urandom_range(99);
    if (!sb.idle()) t.operation = 2'($urandom);
    else if (!allow_cmd || r < 4) t.operation = OP_NONE;
    else if (r < 42) t.operation = OP_READ;
    else if (r < 82) t.operation = OP_WRITE;
    else t.operation = OP_BUS_RESET;
    case ($urandom_range(7))
      0: t.page = '0;
      1: t.page = '1;
      2: t.page = BANK_LIMIT;
      3: t.page = BANK_LIMIT + 1'b1;
      default: t.page = 14'($urandom);
    endcase
    t.slave_addr  = 2'($urandom);
    t.wdata_valid = $urandom_range(3) != 0;
    t.wdata       = 8'($urandom);
    // short bursts of SCL held low by the slave
    if (stretch_left != 0) begin
      stretch_left--;
      t.scl_in = 1'b0;
    end else if ($urandom_range(39) == 0) begin
      stretch_left = $urandom_range(5);
      t.scl_in = 1'b0;
    end else begin
      t.scl_in = 1'b1;
    end
    t.sda_in = 1'($urandom);
    return t;
  endfunction

  task automatic send_tick(input tick_in_t t);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= t.operation;
    page        <= t.page;
    slave_addr  <= t.slave_addr;
    wdata_valid <= t.wdata_valid;
    wdata       <= t.wdata;
    scl_in      <= t.scl_in;
    sda_in      <= t.sda_in;
    do @(posedge clk); while (in_stall_o);
    sb.take_tick(t);
  endtask

  task automatic issue(input logic [1:0] op, input logic [13:0] pg, input logic [1:0] sl);
    tick_in_t t;
    t = make_tick(1'b0);
    t.operation  = op;
    t.page       = pg;
    t.slave_addr = sl;
    send_tick(t);
  endtask

  task automatic run_ticks(input int unsigned n);
    repeat (n) send_tick(make_tick(1'b0));
  endtask

  task automatic drain_idle();
    while (!sb.idle()) send_tick(make_tick(1'b0));
  endtask

  // called straight after an accepted transaction, so valid drops on that edge
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_tick_res.size() != 0);
  endtask

  task automatic program_regs(input logic [15:0] h, input logic [19:0] w, input logic p);
    logic [1:0]  idxs [3];
    logic [19:0] vals [3];
    idxs = '{CFG_IDX_HALF_PHASE, CFG_IDX_WRITE_WAIT, CFG_IDX_PAGE_SIZE};
    vals = '{20'(h), w, 20'(p)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready_o);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [15:0] h, input logic [19:0] w, input logic p,
                              input bit quiet, input int unsigned count);
    calm = quiet;
    program_regs(h, w, p);
    repeat (count) send_tick(make_tick(1'b1));
    drain_idle();
    settle();
  endtask

  // result side: check every accepted transaction, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      sb.check_result({scl_low_o, sda_low_o, busy_res_o, wdata_req_o,
                       rdata_valid_o, rdata_o, rdata_last_o, done_res_o});
      res_seen++;
      // long hold-off so the pipe backs up into the tick input
      if (res_seen % 3000 == 500) hold_left = $urandom_range(60, 120);
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset register values: bus recovery with every header bit set
    issue(OP_BUS_RESET, '1, 2'd3);
    drain_idle();
    settle();

    program_regs(16'd0, 20'd3, 1'b0);
    issue(OP_READ, '0, 2'd0);
    drain_idle();
    issue(OP_READ, BANK_LIMIT + 1'b1, 2'd2);
    drain_idle();
    issue(OP_WRITE, BANK_LIMIT, 2'd1);
    drain_idle();
    issue(OP_WRITE, '1, 2'd3);
    drain_idle();
    settle();

    // longest half phase, cut back to zero mid-command
    program_regs(16'hFFFF, 20'd3, 1'b0);
    issue(OP_BUS_RESET, '0, 2'd0);
    run_ticks(40);
    settle();
    program_regs(16'd0, 20'd3, 1'b0);
    drain_idle();
    settle();

    // longest write wait, shortened once the write is sitting in it
    program_regs(16'd0, 20'hFFFFF, 1'b0);
    issue(OP_WRITE, 14'h2AAA, 2'd2);
    while (sb.st != ST_WAIT) send_tick(make_tick(1'b0));
    run_ticks(30);
    settle();
    program_regs(16'd0, 20'd0, 1'b0);
    drain_idle();
    settle();

    // long page read switched to short pages well past the short length
    program_regs(16'd0, 20'd2, 1'b1);
    issue(OP_READ, 14'h1555, 2'd1);
    run_ticks(1000);
    settle();
    program_regs(16'd0, 20'd2, 1'b0);
    drain_idle();
    settle();

    random_phase(16'd0, 20'd0, 1'b0, 1'b0, 350);
    random_phase(16'd2, 20'd5, 1'b0, 1'b1, 250);
    random_phase(16'd0, 20'd1, 1'b1, 1'b0, 350);
    random_phase(16'd1, 20'd0, 1'b0, 1'b0, 300);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_tick_res.size() == 0) begin
      $display("PASS i2c_eeprom_page_master");
    end else begin
      $display("FAIL i2c_eeprom_page_master");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("FAIL i2c_eeprom_page_master");
    $finish;
  end

endmodule

### i2c_eeprom_page_master.f
+incdir+hw/rtl
hw/rtl/i2cep_pkg.sv
hw/rtl/i2cep_cfg_regs.sv
hw/rtl/i2cep_seq.sv
hw/rtl/i2c_eeprom_page_master.sv
hw/rtl/i2cep_checker.sv
bench/i2c_eeprom_page_master_tb.sv
